>>> design/ucfp_pkg.sv
// Package: types, constants and control store of the command frame parser.
`timescale 1ns / 1ps

package ucfp_pkg;

  localparam int unsigned WinDepth = 7;
  localparam int unsigned LinkLen  = 4;
  localparam int unsigned ValueLen = 7;

  localparam logic [7:0] SyncValue = 8'hAA;
  localparam logic [7:0] SyncLink  = 8'hBB;
  localparam logic [7:0] CodeCc    = 8'hCC;
  localparam logic [7:0] CodeDd    = 8'hDD;
  localparam logic [7:0] CodeEe    = 8'hEE;

  typedef logic [2:0] fill_t;
  typedef logic [1:0] step_t;

  localparam step_t StepIdle = 2'd0;
  localparam step_t StepScan = 2'd1;
  localparam step_t StepEmit = 2'd2;

  typedef enum logic [2:0] {
    KIND_VALUES    = 3'd0,
    KIND_WIFI_UP   = 3'd1,
    KIND_WIFI_DOWN = 3'd2,
    KIND_MQTT_UP   = 3'd3,
    KIND_MQTT_DOWN = 3'd4,
    KIND_CFG_END   = 3'd5,
    KIND_CFG_START = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    RES_WAIT = 2'd0,
    RES_DROP = 2'd1,
    RES_DONE = 2'd2
  } scan_res_e;

  typedef enum logic [1:0] {
    COND_INPUT   = 2'd0,
    COND_SCAN    = 2'd1,
    COND_OUTFREE = 2'd2
  } cond_e;

  // One control word: branch condition, datapath enables, targets by outcome.
  typedef struct packed {
    cond_e cond;
    logic  take;
    logic  scan;
    logic  emit;
    step_t tgt0;
    step_t tgt1;
    step_t tgt2;
  } ctrl_t;

  typedef struct packed {
    logic      in_fire;
    scan_res_e res;
    logic      out_free;
  } status_t;

  localparam ctrl_t UcodeRom [4] = '{
    '{cond: COND_INPUT, take: 1'b1, scan: 1'b0, emit: 1'b0,
      tgt0: StepIdle, tgt1: StepScan, tgt2: StepIdle},
    '{cond: COND_SCAN, take: 1'b0, scan: 1'b1, emit: 1'b0,
      tgt0: StepIdle, tgt1: StepScan, tgt2: StepEmit},
    '{cond: COND_OUTFREE, take: 1'b0, scan: 1'b0, emit: 1'b1,
      tgt0: StepEmit, tgt1: StepIdle, tgt2: StepIdle},
    '{cond: COND_INPUT, take: 1'b1, scan: 1'b0, emit: 1'b0,
      tgt0: StepIdle, tgt1: StepScan, tgt2: StepIdle}
  };

endpackage

>>> design/ucfp_rom.sv
// Control store: maps the step counter to its control word.
`timescale 1ns / 1ps

module ucfp_rom (
  input  ucfp_pkg::step_t step_i,
  output ucfp_pkg::ctrl_t ctrl_o
);

  assign ctrl_o = ucfp_pkg::UcodeRom[step_i];

endmodule

>>> design/ucfp_seq.sv
// Sequencer: step counter with conditional jumps taken from the control word.
`timescale 1ns / 1ps

module ucfp_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ucfp_pkg::ctrl_t   ctrl_i,
  input  ucfp_pkg::status_t status_i,
  output ucfp_pkg::step_t   step_o
);

  ucfp_pkg::step_t step_q, step_d;
  logic [1:0]      outcome;

  always_comb begin
    unique case (ctrl_i.cond)
      ucfp_pkg::COND_INPUT:   outcome = {1'b0, status_i.in_fire};
      ucfp_pkg::COND_SCAN:    outcome = status_i.res;
      ucfp_pkg::COND_OUTFREE: outcome = {1'b0, status_i.out_free};
      default:                outcome = 2'd0;
    endcase
    unique case (outcome)
      2'd1:    step_d = ctrl_i.tgt1;
      2'd2:    step_d = ctrl_i.tgt2;
      default: step_d = ctrl_i.tgt0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ucfp_pkg::StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign step_o = step_q;

endmodule

>>> design/ucfp_dp.sv
// Datapath: byte window, frame classifier, link flags and output register.
`timescale 1ns / 1ps

module ucfp_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ucfp_pkg::ctrl_t   ctrl_i,
  output ucfp_pkg::status_t status_o,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_test_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_kind_o,
  output logic [19:0]       out_data_o
);

  logic [7:0]        win_q [ucfp_pkg::WinDepth];
  logic [7:0]        win_d [ucfp_pkg::WinDepth];
  ucfp_pkg::fill_t   fill_q, fill_d;
  logic              test_q, test_d;
  logic              wifi_q, wifi_d, mqtt_q, mqtt_d, cfg_q, cfg_d;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_kind_q, out_kind_d;
  logic [19:0]       out_data_q, out_data_d;
  ucfp_pkg::scan_res_e res;
  ucfp_pkg::kind_e   kind;
  logic              in_fire, out_free, emit_fire, b2_ok;

  assign in_fire   = in_valid_i & ctrl_i.take;
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_fire = ctrl_i.emit & out_free;

  // One check of the window from its oldest byte.
  always_comb begin
    res  = ucfp_pkg::RES_WAIT;
    kind = ucfp_pkg::KIND_VALUES;
    b2_ok = (win_q[2] == ucfp_pkg::CodeCc) || (win_q[2] == ucfp_pkg::CodeDd) ||
            (win_q[2] == ucfp_pkg::CodeEe);
    if (fill_q == 3'd0) begin
      res = ucfp_pkg::RES_WAIT;
    end else if (win_q[0] == ucfp_pkg::SyncValue) begin
      if (fill_q < 3'd2) res = ucfp_pkg::RES_WAIT;
      else if (win_q[1] != ucfp_pkg::SyncValue) res = ucfp_pkg::RES_DROP;
      else if (fill_q < 3'(ucfp_pkg::ValueLen)) res = ucfp_pkg::RES_WAIT;
      else res = ucfp_pkg::RES_DONE;
    end else if (win_q[0] != ucfp_pkg::SyncLink) begin
      res = ucfp_pkg::RES_DROP;
    end else if (fill_q < 3'd2) begin
      res = ucfp_pkg::RES_WAIT;
    end else if (win_q[1] != ucfp_pkg::SyncLink) begin
      res = ucfp_pkg::RES_DROP;
    end else if (fill_q < 3'd3) begin
      res = ucfp_pkg::RES_WAIT;
    end else if (!b2_ok) begin
      res = ucfp_pkg::RES_DROP;
    end else if (fill_q < 3'(ucfp_pkg::LinkLen)) begin
      res = ucfp_pkg::RES_WAIT;
    end else begin
      res = ucfp_pkg::RES_DONE;
      priority if (win_q[2] == ucfp_pkg::CodeCc && win_q[3] == ucfp_pkg::CodeCc)
        kind = ucfp_pkg::KIND_WIFI_UP;
      else if (win_q[2] == ucfp_pkg::CodeCc && win_q[3] == ucfp_pkg::CodeDd)
        kind = ucfp_pkg::KIND_WIFI_DOWN;
      else if (win_q[2] == ucfp_pkg::CodeDd && win_q[3] == ucfp_pkg::CodeDd)
        kind = ucfp_pkg::KIND_MQTT_UP;
      else if (win_q[2] == ucfp_pkg::CodeDd && win_q[3] == ucfp_pkg::CodeEe)
        kind = ucfp_pkg::KIND_MQTT_DOWN;
      else if (win_q[2] == ucfp_pkg::CodeEe && win_q[3] == ucfp_pkg::CodeDd)
        kind = ucfp_pkg::KIND_CFG_END;
      else if (win_q[2] == ucfp_pkg::CodeEe && win_q[3] == ucfp_pkg::CodeEe)
        kind = ucfp_pkg::KIND_CFG_START;
      else
        res = ucfp_pkg::RES_DROP;
    end
  end

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    test_d      = test_q;
    wifi_d      = wifi_q;
    mqtt_d      = mqtt_q;
    cfg_d       = cfg_q;
    out_kind_d  = out_kind_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q & !out_ready_i;

    if (in_fire) begin
      test_d = in_test_i;
      if (fill_q == 3'(ucfp_pkg::WinDepth)) begin
        for (int i = 0; i < ucfp_pkg::WinDepth - 1; i++) win_d[i] = win_q[i + 1];
        win_d[ucfp_pkg::WinDepth - 1] = in_byte_i;
      end else begin
        win_d[fill_q] = in_byte_i;
        fill_d = fill_q + 3'd1;
      end
    end

    if (ctrl_i.scan && res == ucfp_pkg::RES_DROP) begin
      for (int i = 0; i < ucfp_pkg::WinDepth - 1; i++) win_d[i] = win_q[i + 1];
      fill_d = fill_q - 3'd1;
    end

    if (emit_fire) begin
      unique case (kind)
        ucfp_pkg::KIND_WIFI_UP:   wifi_d = 1'b1;
        ucfp_pkg::KIND_WIFI_DOWN: wifi_d = 1'b0;
        ucfp_pkg::KIND_MQTT_UP:   mqtt_d = 1'b1;
        ucfp_pkg::KIND_MQTT_DOWN: mqtt_d = 1'b0;
        ucfp_pkg::KIND_CFG_END:   cfg_d  = 1'b0;
        ucfp_pkg::KIND_CFG_START: cfg_d  = 1'b1;
        default: ;
      endcase
      if (kind == ucfp_pkg::KIND_VALUES) begin
        fill_d = 3'd0;
        out_data_d = {cfg_d, mqtt_d, wifi_d, !test_q, win_q[4], win_q[3]};
      end else begin
        for (int i = 0; i < ucfp_pkg::WinDepth - ucfp_pkg::LinkLen; i++)
          win_d[i] = win_q[i + ucfp_pkg::LinkLen];
        fill_d = fill_q - 3'(ucfp_pkg::LinkLen);
        out_data_d = {cfg_d, mqtt_d, wifi_d, 1'b0, 8'd0, 8'd0};
      end
      out_kind_d  = kind;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      wifi_q      <= 1'b0;
      mqtt_q      <= 1'b0;
      cfg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      wifi_q      <= wifi_d;
      mqtt_q      <= mqtt_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    test_q     <= test_d;
    out_kind_q <= out_kind_d;
    out_data_q <= out_data_d;
  end

  assign status_o    = '{in_fire: in_fire, res: res, out_free: out_free};
  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 3'(ucfp_pkg::WinDepth))
    else $error("window fill out of range");

  a_fill_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> fill_q != 3'd0)
    else $error("window empty after byte taken");

  a_drop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.scan && res == ucfp_pkg::RES_DROP) |=> fill_q == $past(fill_q) - 3'd1)
    else $error("drop did not remove exactly one byte");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.emit))
    else $error("result shown without emit step");
`endif

endmodule

>>> design/uart_command_frame_parser.sv
// Top level of the serial command frame parser: sequencer, control store, datapath.
//
//  channel  dir  tdata (low bit up)                                    tuser
//  s_axis   in   rx_byte[7:0], test_active[8], zero pad [15:9]         -
//  m_axis   out  attention_value[7:0], meditation_value[15:8],         frame_kind[2:0]
//                values_taken[16], wifi_connected[17],
//                mqtt_connected[18], wifi_config_active[19], pad [23:20]
//
// Each byte is taken, then checked once in the window and once more per dropped byte,
// with at most four drops. A byte that completes a frame is taken, checked once and then
// passes to the emit step. The scan loop of the microprogram sets this order.
// Reset clears the window fill, link flags and output valid; no clearing pass.
// A result waits in the output register while the next byte is taken; a new frame
// holds in the emit step until that register is free.
`timescale 1ns / 1ps

module uart_command_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte, test_active
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // attention, meditation, taken, wifi, mqtt, cfg
  output logic [2:0]  m_axis_tuser    // frame_kind
);

  ucfp_pkg::step_t   step;
  ucfp_pkg::ctrl_t   ctrl;
  ucfp_pkg::status_t status;
  logic [19:0]       out_data;

  ucfp_rom u_rom (
    .step_i (step),
    .ctrl_o (ctrl)
  );

  ucfp_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .status_i (status),
    .step_o   (step)
  );

  ucfp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata[7:0]),
    .in_test_i   (s_axis_tdata[8]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (out_data)
  );

  assign s_axis_tready = ctrl.take;
  assign m_axis_tdata  = {4'd0, out_data};

endmodule

>>> dv/uart_command_frame_parser_test.sv
// Testbench of the serial command frame parser: byte stream in, checked frame results out.
`timescale 1ns / 1ps

module uart_command_frame_parser_test;

  typedef struct packed {
    ucfp_pkg::kind_e kind;
    logic [7:0]      attention;
    logic [7:0]      meditation;
    logic            taken;
    logic            wifi;
    logic            mqtt;
    logic            cfg;
  } frame_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // rx_byte, test_active
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // attention, meditation, taken, wifi, mqtt, cfg
  logic [2:0]  m_axis_tuser;   // frame_kind

  // predictor state
  logic [7:0]  win_bytes [ucfp_pkg::WinDepth];
  int unsigned win_fill;
  logic        wifi_on;
  logic        mqtt_on;
  logic        cfg_on;

  frame_t      frames_due [$];
  int          err_count;
  bit          idle_en;
  bit          hold_req;

  uart_command_frame_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [15:0] link_code(ucfp_pkg::kind_e k);
    case (k)
      ucfp_pkg::KIND_WIFI_UP:   return {ucfp_pkg::CodeCc, ucfp_pkg::CodeCc};
      ucfp_pkg::KIND_WIFI_DOWN: return {ucfp_pkg::CodeCc, ucfp_pkg::CodeDd};
      ucfp_pkg::KIND_MQTT_UP:   return {ucfp_pkg::CodeDd, ucfp_pkg::CodeDd};
      ucfp_pkg::KIND_MQTT_DOWN: return {ucfp_pkg::CodeDd, ucfp_pkg::CodeEe};
      ucfp_pkg::KIND_CFG_END:   return {ucfp_pkg::CodeEe, ucfp_pkg::CodeDd};
      ucfp_pkg::KIND_CFG_START: return {ucfp_pkg::CodeEe, ucfp_pkg::CodeEe};
      default:                  return '0;
    endcase
  endfunction

  function automatic void shift_window(int unsigned n);
    if (n >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int i = 0; i + n < win_fill; i++) win_bytes[i] = win_bytes[i + n];
      win_fill -= n;
    end
  endfunction

  function automatic ucfp_pkg::scan_res_e scan_window(output ucfp_pkg::kind_e kind);
    logic [15:0] code;
    kind = ucfp_pkg::KIND_VALUES;
    if (win_fill == 0) return ucfp_pkg::RES_WAIT;
    if (win_bytes[0] == ucfp_pkg::SyncValue) begin
      if (win_fill < 2) return ucfp_pkg::RES_WAIT;
      if (win_bytes[1] != ucfp_pkg::SyncValue) begin
        shift_window(1);
        return ucfp_pkg::RES_DROP;
      end
      if (win_fill < ucfp_pkg::ValueLen) return ucfp_pkg::RES_WAIT;
      return ucfp_pkg::RES_DONE;
    end
    if (win_bytes[0] != ucfp_pkg::SyncLink) begin
      shift_window(1);
      return ucfp_pkg::RES_DROP;
    end
    if (win_fill < 2) return ucfp_pkg::RES_WAIT;
    if (win_bytes[1] != ucfp_pkg::SyncLink) begin
      shift_window(1);
      return ucfp_pkg::RES_DROP;
    end
    if (win_fill < 3) return ucfp_pkg::RES_WAIT;
    if (win_bytes[2] != ucfp_pkg::CodeCc && win_bytes[2] != ucfp_pkg::CodeDd &&
        win_bytes[2] != ucfp_pkg::CodeEe) begin
      shift_window(1);
      return ucfp_pkg::RES_DROP;
    end
    if (win_fill < ucfp_pkg::LinkLen) return ucfp_pkg::RES_WAIT;
    code = {win_bytes[2], win_bytes[3]};
    for (int k = ucfp_pkg::KIND_WIFI_UP; k <= ucfp_pkg::KIND_CFG_START; k++) begin
      if (link_code(ucfp_pkg::kind_e'(k)) == code) begin
        kind = ucfp_pkg::kind_e'(k);
        return ucfp_pkg::RES_DONE;
      end
    end
    shift_window(1);
    return ucfp_pkg::RES_DROP;
  endfunction

  // Takes one byte into the window and queues the frame it completes, if any.
  function automatic void predict_frame(logic [7:0] b, logic test);
    ucfp_pkg::scan_res_e res;
    ucfp_pkg::kind_e     kind;
    frame_t              f;
    if (win_fill >= ucfp_pkg::WinDepth) shift_window(1);
    win_bytes[win_fill] = b;
    win_fill++;
    res = ucfp_pkg::RES_DROP;
    for (int i = 0; i <= ucfp_pkg::WinDepth && res == ucfp_pkg::RES_DROP; i++)
      res = scan_window(kind);
    if (res != ucfp_pkg::RES_DONE) return;
    f = '0;
    f.kind = kind;
    case (kind)
      ucfp_pkg::KIND_VALUES: begin
        f.attention  = win_bytes[3];
        f.meditation = win_bytes[4];
        f.taken      = !test;
      end
      ucfp_pkg::KIND_WIFI_UP:   wifi_on = 1'b1;
      ucfp_pkg::KIND_WIFI_DOWN: wifi_on = 1'b0;
      ucfp_pkg::KIND_MQTT_UP:   mqtt_on = 1'b1;
      ucfp_pkg::KIND_MQTT_DOWN: mqtt_on = 1'b0;
      ucfp_pkg::KIND_CFG_END:   cfg_on  = 1'b0;
      default:                  cfg_on  = 1'b1;
    endcase
    shift_window(kind == ucfp_pkg::KIND_VALUES ? ucfp_pkg::ValueLen : ucfp_pkg::LinkLen);
    f.wifi = wifi_on;
    f.mqtt = mqtt_on;
    f.cfg  = cfg_on;
    frames_due.push_back(f);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return ucfp_pkg::SyncValue;
      1:       return ucfp_pkg::SyncLink;
      2:       return ucfp_pkg::CodeCc;
      3:       return ucfp_pkg::CodeDd;
      4:       return ucfp_pkg::CodeEe;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic test);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, test, b};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame(b, test);
  endtask

  task automatic send_value(input logic [7:0] att, input logic [7:0] med, input logic test);
    send_byte(ucfp_pkg::SyncValue, rand_bit());
    send_byte(ucfp_pkg::SyncValue, rand_bit());
    send_byte(rand_byte(), rand_bit());
    send_byte(att, rand_bit());
    send_byte(med, rand_bit());
    send_byte(rand_byte(), rand_bit());
    send_byte(rand_byte(), test);
  endtask

  task automatic send_link(input ucfp_pkg::kind_e k);
    logic [15:0] code;
    code = link_code(k);
    send_byte(ucfp_pkg::SyncLink, rand_bit());
    send_byte(ucfp_pkg::SyncLink, rand_bit());
    send_byte(code[15:8], rand_bit());
    send_byte(code[7:0], rand_bit());
  endtask

  function automatic ucfp_pkg::kind_e rand_link_kind();
    return ucfp_pkg::kind_e'($urandom_range(ucfp_pkg::KIND_WIFI_UP,
                                            ucfp_pkg::KIND_CFG_START));
  endfunction

  // Mostly whole frames with random content; the rest broken frames and noise.
  task automatic send_random_burst(output int counted);
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    counted = 0;
    if (sel < 40) begin
      send_value(rand_byte(), rand_byte(), rand_bit());
      counted = ucfp_pkg::ValueLen;
    end else if (sel < 80) begin
      send_link(rand_link_kind());
      counted = ucfp_pkg::LinkLen;
    end else if (sel < 85) begin
      send_byte(ucfp_pkg::SyncValue, rand_bit());
      send_byte(noise_byte(), rand_bit());
      counted = 2;
    end else if (sel < 90) begin
      send_byte(ucfp_pkg::SyncLink, rand_bit());
      send_byte(ucfp_pkg::SyncLink, rand_bit());
      send_byte(noise_byte(), rand_bit());
      send_byte(noise_byte(), rand_bit());
      counted = 4;
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(noise_byte(), rand_bit());
      counted = n;
    end
  endtask

  task automatic wait_drain();
    while (frames_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int target);
    int total;
    int n;
    total = 0;
    while (total < target) begin
      send_random_burst(n);
      total += n;
    end
  endtask

  // Bad lead, bad second byte, bad link code, full window, every frame kind.
  task automatic test_directed();
    send_byte(ucfp_pkg::SyncValue, 1'b0);        // AA then BB: drop
    send_link(ucfp_pkg::KIND_WIFI_UP);
    send_byte(ucfp_pkg::SyncLink, 1'b0);         // BB BB CC BB: bad fourth code
    send_byte(ucfp_pkg::SyncLink, 1'b1);
    send_byte(ucfp_pkg::CodeCc, 1'b0);
    send_byte(ucfp_pkg::SyncLink, 1'b1);
    send_link(ucfp_pkg::KIND_WIFI_DOWN);
    send_byte(ucfp_pkg::SyncLink, 1'b0);         // BB BB AA: bad third code
    send_byte(ucfp_pkg::SyncLink, 1'b0);
    send_value(8'h00, 8'hFF, 1'b0);
    send_link(ucfp_pkg::KIND_MQTT_UP);
    send_link(ucfp_pkg::KIND_CFG_START);
    send_link(ucfp_pkg::KIND_MQTT_DOWN);
    send_link(ucfp_pkg::KIND_CFG_END);
    send_value(8'hFF, 8'h00, 1'b1);
  endtask

  task automatic test_random_traffic();
    idle_en = 1'b1;
    run_random(300);
  endtask

  // Output held off while input keeps coming, so the input side backs up.
  task automatic test_output_holdoff();
    hold_req = 1'b1;
    repeat (24) send_link(rand_link_kind());
  endtask

  task automatic test_drain_pause();
    run_random(40);
    wait_drain();
    run_random(40);
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    run_random(80);
  endtask

  // result sink: random stalls plus a long hold-off on request
  initial begin : sink
    int     hold_left;
    int     stall_left;
    frame_t seen;
    frame_t want;
    hold_left     = 0;
    stall_left    = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        seen = {ucfp_pkg::kind_e'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[15:8],
                m_axis_tdata[16], m_axis_tdata[17], m_axis_tdata[18], m_axis_tdata[19]};
        if (frames_due.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected result: kind %0d", m_axis_tuser);
        end else begin
          want = frames_due.pop_front();
          if (seen !== want) begin
            err_count++;
            if (err_count <= 10)
              $display({"mismatch exp/act: kind %0d/%0d att %02h/%02h med %02h/%02h",
                        " taken %b/%b wifi %b/%b mqtt %b/%b cfg %b/%b"},
                       want.kind, seen.kind, want.attention, seen.attention,
                       want.meditation, seen.meditation, want.taken, seen.taken,
                       want.wifi, seen.wifi, want.mqtt, seen.mqtt, want.cfg, seen.cfg);
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    win_bytes     = '{default: '0};
    win_fill      = 0;
    wifi_on       = 1'b0;
    mqtt_on       = 1'b0;
    cfg_on        = 1'b0;
    err_count     = 0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_output_holdoff();
    test_drain_pause();
    test_no_idle();
    s_axis_tvalid <= 1'b0;
    wait_drain();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && frames_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
